[rtl/pi_nco_phase_locked_loop_top_macros.svh]
// ---------------------------------------------------------------------------
// PI NCO PLL assertion macros
// Clocked assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PI_NCO_PHASE_LOCKED_LOOP_TOP_MACROS_SVH
`define PI_NCO_PHASE_LOCKED_LOOP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PNPLL_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("pnpll check failed");
`define PNPLL_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error("pnpll bad cond");
`else
`define PNPLL_ASSERT(lbl, ck, rn, prop)
`define PNPLL_NEVER(lbl, ck, rn, cond)
`endif
`endif

[rtl/pnpll_pkg.sv]
// ---------------------------------------------------------------------------
// PI NCO PLL package
// Sequencer states, register indexes, formats and the quarter-wave table.
// ---------------------------------------------------------------------------
package pnpll_pkg;

  localparam int PHASE_W  = 32;
  localparam int SAMPLE_W = 16;
  localparam int QADDR_W  = 10;
  localparam int QTR_LEN  = 1 << QADDR_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic signed [63:0] AMP = 64'sd32767;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTEG_GAIN  = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_NCO_GAIN    = 3'd2,
    REG_LO_STEP     = 3'd3,
    REG_HC_PER_SYM  = 3'd4,
    REG_FREQ_COEFF  = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MI, S_MP, S_ML, S_NL, S_NH, S_PH, S_OM, S_DF, S_F2, S_WB
  } state_t;

  typedef logic [SAMPLE_W-1:0] qw_tab_t [0:QTR_LEN];

  function automatic logic [SAMPLE_W-1:0] qw_entry(int unsigned i);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x = (PI_Q30 * 64'(i)) >> (QADDR_W + 1);
    term = x;
    sum = signed'(x);
    for (int unsigned k = 1; k <= 10; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(2 * k * (2 * k + 1));
      if (k[0]) sum = sum - signed'(term);
      else      sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    v = (sum * AMP + (64'sd1 <<< 29)) >>> 30;
    if (v > AMP) v = AMP;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic qw_tab_t qw_build();
    qw_tab_t t;
    for (int unsigned i = 0; i <= QTR_LEN; i++) t[i] = qw_entry(i);
    return t;
  endfunction

  localparam qw_tab_t QW_TAB = qw_build();

endpackage

[rtl/pnpll_if.sv]
// ---------------------------------------------------------------------------
// PI NCO PLL channels
// Valid/ready channels for samples, results and register writes.
// ---------------------------------------------------------------------------
interface pnpll_in_if;
  logic valid;
  logic ready;
  logic signed [pnpll_pkg::SAMPLE_W-1:0] phase_error;
  modport source (output valid, output phase_error, input ready);
  modport sink   (input valid, input phase_error, output ready);
endinterface

interface pnpll_out_if;
  logic valid;
  logic ready;
  logic signed [pnpll_pkg::SAMPLE_W-1:0] nco_cos;
  logic signed [pnpll_pkg::SAMPLE_W-1:0] nco_neg_sin;
  logic [pnpll_pkg::PHASE_W-1:0] phase_now;
  logic [pnpll_pkg::PHASE_W-1:0] freq_smoothed;
  logic symbol_tick;
  modport source (output valid, output nco_cos, output nco_neg_sin, output phase_now,
                  output freq_smoothed, output symbol_tick, input ready);
  modport sink   (input valid, input nco_cos, input nco_neg_sin, input phase_now,
                  input freq_smoothed, input symbol_tick, output ready);
endinterface

interface pnpll_cfg_if;
  logic valid;
  logic ready;
  logic [pnpll_pkg::CFG_IDX_W-1:0] index;
  logic [pnpll_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pi_nco_phase_locked_loop_top.sv]
// ---------------------------------------------------------------------------
// PI NCO phase-locked loop
// One phase-error beat in, one oscillator beat out. A sequencer steps a
// single shared 33x18 multiplier through the integrator, proportional, NCO
// and frequency-filter products; the quarter-wave ROM is read twice. A
// new sample is taken only once the sequencer is back in idle, after
// the six multiplier passes and the two ROM reads. The result waits in
// an output register; the last step stalls only if that register is
// still full.
// Register writes are taken only while the sequencer is idle.
// ---------------------------------------------------------------------------
`include "pi_nco_phase_locked_loop_top_macros.svh"

module pi_nco_phase_locked_loop_top (
  input  logic            clk,
  input  logic            rst_n,
  pnpll_in_if.sink        in_bus,
  pnpll_out_if.source     out_bus,
  pnpll_cfg_if.sink       cfg_bus
);

  pnpll_pkg::state_t state_r, state_nxt;

  logic [15:0] integ_gain_r, prop_gain_r, nco_gain_r, hc_per_sym_r, coeff_r;
  logic [31:0] lo_step_r;

  logic signed [31:0] acc_r;
  logic [31:0] loop_r, free_r, prev_r, facc_r, omega_r, diff_r;
  logic [15:0] hc_r;
  logic signed [15:0] err_r;
  logic signed [41:0] pi_r;
  logic [47:0] part_r;
  logic [1:0] cos_quad_r;
  logic signed [15:0] cos_r;
  logic [15:0] rom_r;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod_r;
  logic mul_en;

  logic [10:0] rom_addr;
  logic [31:0] rom_ph;
  logic go;

  logic signed [33:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic [46:0] nco_sum;
  logic [31:0] loop_new;
  logic [31:0] diff_raw;
  logic [49:0] f_sum;
  logic crossed;
  logic [15:0] hc_inc;

  logic out_valid_r;
  logic signed [15:0] o_cos_r, o_sin_r;
  logic [31:0] o_phase_r, o_freq_r;
  logic o_tick_r;

  assign in_bus.ready = (state_r == pnpll_pkg::S_IDLE);
  assign cfg_bus.ready = (state_r == pnpll_pkg::S_IDLE);
  assign go = !out_valid_r || out_bus.ready;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pnpll_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mul_en = 1'b1;
    mul_a = 33'sd0;
    mul_b = 18'sd0;
    case (state_r)
      pnpll_pkg::S_IDLE: begin
        mul_en = 1'b0;
        if (in_bus.valid) state_nxt = pnpll_pkg::S_MI;
      end
      pnpll_pkg::S_MI: begin
        mul_a = 33'(err_r);
        mul_b = signed'({2'b00, integ_gain_r});
        state_nxt = pnpll_pkg::S_MP;
      end
      pnpll_pkg::S_MP: begin
        mul_a = 33'(err_r);
        mul_b = signed'({2'b00, prop_gain_r});
        state_nxt = pnpll_pkg::S_ML;
      end
      pnpll_pkg::S_ML: begin
        mul_en = 1'b0;
        state_nxt = pnpll_pkg::S_NL;
      end
      pnpll_pkg::S_NL: begin
        mul_a = signed'({1'b0, pi_r[31:0]});
        mul_b = signed'({2'b00, nco_gain_r});
        state_nxt = pnpll_pkg::S_NH;
      end
      pnpll_pkg::S_NH: begin
        mul_a = 33'($signed(pi_r[41:32]));
        mul_b = signed'({2'b00, nco_gain_r});
        state_nxt = pnpll_pkg::S_PH;
      end
      pnpll_pkg::S_PH: begin
        mul_en = 1'b0;
        state_nxt = pnpll_pkg::S_OM;
      end
      pnpll_pkg::S_OM: begin
        mul_en = 1'b0;
        state_nxt = pnpll_pkg::S_DF;
      end
      pnpll_pkg::S_DF: begin
        mul_a = signed'({1'b0, facc_r});
        mul_b = signed'({2'b00, coeff_r});
        state_nxt = pnpll_pkg::S_F2;
      end
      pnpll_pkg::S_F2: begin
        mul_a = signed'({1'b0, diff_r});
        mul_b = signed'(18'h10000 - {2'b00, coeff_r});
        state_nxt = pnpll_pkg::S_WB;
      end
      pnpll_pkg::S_WB: begin
        mul_en = 1'b0;
        if (go) state_nxt = pnpll_pkg::S_IDLE;
      end
      default: begin
        mul_en = 1'b0;
        state_nxt = pnpll_pkg::S_IDLE;
      end
    endcase
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
  end

  // quarter-wave ROM
  assign rom_ph = (state_r == pnpll_pkg::S_DF) ? omega_r + 32'h4000_0000 : omega_r;
  assign rom_addr = rom_ph[30] ? 11'(pnpll_pkg::QTR_LEN) - {1'b0, rom_ph[29:20]}
                               : {1'b0, rom_ph[29:20]};

  always_ff @(posedge clk) begin
    rom_r <= pnpll_pkg::QW_TAB[rom_addr];
  end

  // datapath
  assign acc_sum = 34'(acc_r) + 34'($signed(prod_r[32:0]));
  assign acc_sat = (acc_sum > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (acc_sum < -34'sh0_8000_0000) ? 32'sh8000_0000 : acc_sum[31:0];
  assign nco_sum = part_r[46:0] + {prod_r[14:0], 32'h0};
  assign loop_new = loop_r + nco_sum[46:15];
  assign diff_raw = omega_r - prev_r;
  assign f_sum = {2'b00, part_r} + {1'b0, prod_r[48:0]};
  assign crossed = (prev_r <= 32'h8000_0000 && omega_r >= 32'h8000_0000 &&
                    omega_r != prev_r) || (prev_r > omega_r);
  assign hc_inc = hc_r + 16'(crossed);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_gain_r <= 16'd0;
      prop_gain_r  <= 16'd51;
      nco_gain_r   <= 16'd0;
      lo_step_r    <= 32'd0;
      hc_per_sym_r <= 16'd2;
      coeff_r      <= 16'd65143;
      acc_r        <= 32'sd0;
      loop_r       <= 32'd0;
      free_r       <= 32'd0;
      prev_r       <= 32'd0;
      facc_r       <= 32'd0;
      hc_r         <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          pnpll_pkg::REG_INTEG_GAIN: integ_gain_r <= cfg_bus.data[15:0];
          pnpll_pkg::REG_PROP_GAIN:  prop_gain_r  <= cfg_bus.data[15:0];
          pnpll_pkg::REG_NCO_GAIN:   nco_gain_r   <= cfg_bus.data[15:0];
          pnpll_pkg::REG_LO_STEP: begin
            lo_step_r <= cfg_bus.data;
            facc_r    <= cfg_bus.data;
          end
          pnpll_pkg::REG_HC_PER_SYM: hc_per_sym_r <= cfg_bus.data[15:0];
          pnpll_pkg::REG_FREQ_COEFF: coeff_r      <= cfg_bus.data[15:0];
          default: ;
        endcase
      end
      if (state_r == pnpll_pkg::S_MP) acc_r <= acc_sat;
      if (state_r == pnpll_pkg::S_PH) loop_r <= loop_new;
      if (out_valid_r && out_bus.ready) out_valid_r <= 1'b0;
      if (state_r == pnpll_pkg::S_WB && go) begin
        facc_r <= f_sum[47:16];
        free_r <= free_r + lo_step_r;
        prev_r <= omega_r;
        if (hc_inc >= hc_per_sym_r) hc_r <= 16'd0;
        else                        hc_r <= hc_inc;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) err_r <= in_bus.phase_error;
    if (state_r == pnpll_pkg::S_ML)
      pi_r <= 42'($signed(prod_r[32:0])) * 42'sd256 + 42'(acc_r);
    if (state_r == pnpll_pkg::S_NH) part_r <= prod_r[47:0];
    if (state_r == pnpll_pkg::S_OM) omega_r <= free_r + loop_r;
    if (state_r == pnpll_pkg::S_DF) begin
      diff_r     <= (diff_raw == 32'd0) ? 32'hFFFF_FFFF : diff_raw;
      cos_quad_r <= rom_ph[31:30];
    end
    if (state_r == pnpll_pkg::S_F2) begin
      part_r <= prod_r[47:0];
      cos_r  <= cos_quad_r[1] ? -signed'(rom_r) : signed'(rom_r);
    end
    if (state_r == pnpll_pkg::S_WB && go) begin
      o_cos_r   <= cos_r;
      o_sin_r   <= omega_r[31] ? signed'(rom_r) : -signed'(rom_r);
      o_phase_r <= omega_r;
      o_freq_r  <= f_sum[47:16];
      o_tick_r  <= (hc_inc >= hc_per_sym_r);
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.nco_cos       = o_cos_r;
  assign out_bus.nco_neg_sin   = o_sin_r;
  assign out_bus.phase_now     = o_phase_r;
  assign out_bus.freq_smoothed = o_freq_r;
  assign out_bus.symbol_tick   = o_tick_r;

  `PNPLL_ASSERT(a_busy_after_accept, clk, rst_n, (in_bus.valid && in_bus.ready) |=> state_r == pnpll_pkg::S_MI)
  `PNPLL_ASSERT(a_tick_clears, clk, rst_n, (state_r == pnpll_pkg::S_WB && go && hc_inc >= hc_per_sym_r) |=> hc_r == 16'd0)
  `PNPLL_ASSERT(a_stall_holds, clk, rst_n, (state_r == pnpll_pkg::S_WB && !go) |=> $stable(prod_r) && $stable(part_r))
  `PNPLL_NEVER(a_cfg_when_busy, clk, rst_n, cfg_bus.ready && state_r != pnpll_pkg::S_IDLE)

endmodule

[tb/pi_nco_phase_locked_loop_top_tb.sv]
// ---------------------------------------------------------------------------
// PI NCO phase-locked loop testbench
// Drives phase-error beats and register writes into the loop and checks
// every result beat against a cycle-free predictor of the PI filter, NCO,
// frequency smoother, symbol counter and quarter-wave lookup.
// ---------------------------------------------------------------------------
module pi_nco_phase_locked_loop_top_tb;

  typedef struct packed {
    logic signed [15:0] cos_v;
    logic signed [15:0] nsin_v;
    logic [31:0]        phase;
    logic [31:0]        freq;
    logic               tick;
  } nco_beat_t;

  class pll_scoreboard;
    int unsigned       tab [0:1024];
    logic [15:0]       ki, kp, kn, hps, coeff;
    logic [31:0]       lo_step;
    logic signed [31:0] integ;
    logic [31:0]       loop_ph, free_ph, prev_ph, freq_acc;
    logic [15:0]       hc_cnt;
    nco_beat_t         pending [$];
    int                errors;

    function new();
      logic [63:0] x, term;
      logic signed [63:0] sum, v;
      for (int unsigned i = 0; i <= 1024; i++) begin
        x = (64'd3373259426 * 64'(i)) >> 11;
        term = x;
        sum = signed'(x);
        for (int unsigned k = 1; k <= 10; k++) begin
          term = (term * x) >> 30;
          term = (term * x) >> 30;
          term = term / 64'(2 * k * (2 * k + 1));
          sum = k[0] ? sum - signed'(term) : sum + signed'(term);
        end
        if (sum < 0) sum = 0;
        v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
        if (v > 64'sd32767) v = 64'sd32767;
        tab[i] = v[31:0];
      end
      ki = 0; kp = 51; kn = 0; lo_step = 0; hps = 2; coeff = 65143;
      integ = 0; loop_ph = 0; free_ph = 0; prev_ph = 0; freq_acc = 0; hc_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(pnpll_pkg::cfg_reg_t idx, logic [31:0] val);
      case (idx)
        pnpll_pkg::REG_INTEG_GAIN: ki = val[15:0];
        pnpll_pkg::REG_PROP_GAIN:  kp = val[15:0];
        pnpll_pkg::REG_NCO_GAIN:   kn = val[15:0];
        pnpll_pkg::REG_LO_STEP: begin
          lo_step = val;
          freq_acc = val;
        end
        pnpll_pkg::REG_HC_PER_SYM: hps = val[15:0];
        pnpll_pkg::REG_FREQ_COEFF: coeff = val[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] sine_at(logic [31:0] ph);
      logic [1:0] quad;
      logic [9:0] idx;
      int unsigned mag;
      quad = ph[31:30];
      idx = ph[29:20];
      mag = quad[0] ? tab[1024 - idx] : tab[idx];
      return quad[1] ? -16'(mag) : 16'(mag);
    endfunction

    function void note_sample(logic signed [15:0] e);
      logic signed [63:0] ev, acc, pi_out;
      logic [63:0] prod, facc;
      logic [31:0] omega, d;
      nco_beat_t r;
      ev = e;
      acc = 64'(integ) + $signed({48'd0, ki}) * ev;
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      integ = acc[31:0];
      pi_out = $signed({48'd0, kp}) * ev * 64'sd256 + acc;
      prod = pi_out * {48'd0, kn};
      loop_ph = loop_ph + prod[46:15];
      omega = free_ph + loop_ph;
      d = omega - prev_ph;
      if (d == 0) d = '1;
      facc = ({32'd0, freq_acc} * coeff + {32'd0, d} * (64'd65536 - coeff)) >> 16;
      freq_acc = facc[31:0];
      r.tick = 0;
      if ((prev_ph <= 32'h8000_0000 && 32'h8000_0000 <= omega && omega != prev_ph)
          || prev_ph > omega)
        hc_cnt = hc_cnt + 16'd1;
      if (hc_cnt >= hps) begin
        hc_cnt = 0;
        r.tick = 1;
      end
      free_ph = free_ph + lo_step;
      prev_ph = omega;
      r.cos_v = sine_at(omega + 32'h4000_0000);
      r.nsin_v = -sine_at(omega);
      r.phase = omega;
      r.freq = freq_acc;
      pending.push_back(r);
    endfunction

    function void check_beat(nco_beat_t got);
      nco_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cos_v !== want.cos_v) begin
        $display("%0t nco_cos exp %h act %h", $time, want.cos_v, got.cos_v);
        errors++;
      end
      if (got.nsin_v !== want.nsin_v) begin
        $display("%0t nco_neg_sin exp %h act %h", $time, want.nsin_v, got.nsin_v);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $display("%0t phase_now exp %h act %h", $time, want.phase, got.phase);
        errors++;
      end
      if (got.freq !== want.freq) begin
        $display("%0t freq_smoothed exp %h act %h", $time, want.freq, got.freq);
        errors++;
      end
      if (got.tick !== want.tick) begin
        $display("%0t symbol_tick exp %b act %b", $time, want.tick, got.tick);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  int   cycles = 0;
  pll_scoreboard sb = new();

  pnpll_in_if  in_bus ();
  pnpll_out_if out_bus ();
  pnpll_cfg_if cfg_bus ();

  pi_nco_phase_locked_loop_top dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus), .cfg_bus(cfg_bus)
  );

  always #2 clk = ~clk;

  initial begin
    in_bus.valid = 0;
    in_bus.phase_error = 0;
    out_bus.ready = 0;
    cfg_bus.valid = 0;
    cfg_bus.index = pnpll_pkg::REG_INTEG_GAIN;
    cfg_bus.data = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready)
        sb.check_beat({out_bus.nco_cos, out_bus.nco_neg_sin, out_bus.phase_now,
                       out_bus.freq_smoothed, out_bus.symbol_tick});
      out_bus.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic write_reg(pnpll_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_bus.valid <= 1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, val);
    cfg_bus.valid <= 0;
    @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] ki, logic [15:0] kp, logic [15:0] kn,
                           logic [31:0] lo, logic [15:0] hps, logic [15:0] k);
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    write_reg(pnpll_pkg::REG_INTEG_GAIN, ki);
    write_reg(pnpll_pkg::REG_PROP_GAIN, kp);
    write_reg(pnpll_pkg::REG_NCO_GAIN, kn);
    write_reg(pnpll_pkg::REG_LO_STEP, lo);
    write_reg(pnpll_pkg::REG_HC_PER_SYM, hps);
    write_reg(pnpll_pkg::REG_FREQ_COEFF, k);
  endtask

  task automatic send_sample(logic signed [15:0] e);
    if ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_bus.valid <= 1;
    in_bus.phase_error <= e;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_sample(e);
  endtask

  task automatic end_burst();
    in_bus.valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] kn;
    logic [15:0] hps;
    logic [31:0] lo;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_idle = 22;
    recv_idle = 66;
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    end_burst();

    load_regs(16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 16'd0, 16'd0);
    repeat (6) send_sample(16'sd32767);
    repeat (6) send_sample(-16'sd32768);
    end_burst();

    // frozen phase: zero gains and no free-running step
    load_regs(16'd0, 16'd0, 16'd0, 32'd0, 16'd1, 16'hffff);
    repeat (4) send_sample(16'sh1234);
    end_burst();

    for (int ph = 0; ph < 12; ph++) begin
      send_idle = (ph < 4) ? 22 : (ph < 8) ? 66 : 0;
      recv_idle = (ph < 4) ? 66 : (ph < 8) ? 22 : 0;
      kn = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
      hps = ($urandom_range(7) == 0) ? 16'hffff : 16'($urandom_range(1, 8));
      lo = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(0, 32'h0400_0000));
      if (ph == 5)
        load_regs(16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff, 16'hffff);
      else if (ph == 9)
        load_regs(16'd0, 16'd0, 16'd0, 32'd0, 16'd1, 16'd0);
      else
        load_regs(16'($urandom), 16'($urandom), kn, lo, hps, 16'($urandom));
      for (int n = 0; n < 150; n++) begin
        if ($urandom_range(3) == 0)
          send_sample(16'($urandom));
        else
          send_sample(16'($signed(16'($urandom_range(0, 2047))) - 16'sd1024));
      end
      end_burst();
    end

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
